/* hdl/cartesian_target_velocity_steer_core_defines.svh */
// Assertion helpers used by the checker file of the steering core.
`ifndef CARTESIAN_TARGET_VELOCITY_STEER_CORE_DEFINES_SVH
`define CARTESIAN_TARGET_VELOCITY_STEER_CORE_DEFINES_SVH

// Plain property that must hold at every clock edge out of reset.
`define CTVS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("steer core check failed");

// Next-cycle implication out of reset.
`define CTVS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("steer core check failed");

`endif

/* hdl/ctvs_pkg.sv */
package ctvs_pkg;

	// Filter coefficients, signed Q2.30.
	localparam logic signed [32:0] CoefDecay = 33'sd966367642;
	localparam logic signed [32:0] CoefKeep  = 33'sd1063004406;
	localparam logic signed [32:0] CoefNew   = 33'sd10737418;
	localparam int CoefShift = 30;

	localparam logic [30:0] ResetCruise = 31'd1677722;
	localparam logic [30:0] ResetStop   = 31'd335544;
	localparam logic [30:0] ResetFinish = 31'd16777;

	typedef enum logic [2:0] {
		CFG_GOAL_X = 3'd0,
		CFG_GOAL_Y = 3'd1,
		CFG_GOAL_Z = 3'd2,
		CFG_CRUISE = 3'd3,
		CFG_STOP   = 3'd4,
		CFG_FINISH = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_SQ,
		OP_ROOT_INIT,
		OP_ROOT_STEP,
		OP_DECAY_MUL,
		OP_DECAY_ROUND,
		OP_DIV_MUL,
		OP_DIV_STEP,
		OP_DIV_FIX,
		OP_KEEP,
		OP_NEW,
		OP_VEL,
		OP_SPD,
		OP_FIN
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQ,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_AXIS,
		ST_DECAY,
		ST_DIV,
		ST_DIV_FIX,
		ST_KEEP,
		ST_NEW,
		ST_VEL,
		ST_SPD,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] axis;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic far;
	} dp_stat_t;

	typedef struct packed {
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [31:0] goal_z;
		logic [30:0]        cruise_speed;
		logic [30:0]        stop_radius;
		logic [30:0]        finish_speed;
	} cfg_t;

	typedef struct packed {
		logic               finished;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} res_t;

	// Drop the Q2.30 fraction, rounding to nearest with ties away from zero,
	// then saturate to 32 bits.
	function automatic logic signed [31:0] round_sat(input logic signed [64:0] v);
		logic [64:0] mag;
		logic [34:0] r;
		mag = v[64] ? 65'(-v) : 65'(v);
		r = 35'((mag + (65'd1 << (CoefShift - 1))) >> CoefShift);
		if (v[64]) begin
			round_sat = (r > 35'h0_8000_0000) ? 32'sh8000_0000 : 32'(35'd0 - r);
		end else begin
			round_sat = (r > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(r);
		end
	endfunction

endpackage

/* hdl/ctvs_ctrl.sv */
module ctvs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_free,
	input  ctvs_pkg::dp_stat_t  stat,
	output ctvs_pkg::dp_cmd_t   cmd
);

	ctvs_pkg::state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctvs_pkg::ST_IDLE;
			axis_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ctvs_pkg::ST_IDLE: begin
				if (in_valid) state_d = ctvs_pkg::ST_DIFF;
			end
			ctvs_pkg::ST_DIFF: begin
				state_d = ctvs_pkg::ST_SQ;
				axis_d  = '0;
			end
			ctvs_pkg::ST_SQ: begin
				if (axis_q == 2'd2) state_d = ctvs_pkg::ST_ROOT_INIT;
				else axis_d = axis_q + 2'd1;
			end
			ctvs_pkg::ST_ROOT_INIT: begin
				state_d = ctvs_pkg::ST_ROOT;
				cnt_d   = '0;
			end
			ctvs_pkg::ST_ROOT: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_d = ctvs_pkg::ST_AXIS;
					axis_d  = '0;
				end
			end
			ctvs_pkg::ST_AXIS: begin
				cnt_d   = '0;
				state_d = stat.far ? ctvs_pkg::ST_DIV : ctvs_pkg::ST_DECAY;
			end
			ctvs_pkg::ST_DECAY: state_d = ctvs_pkg::ST_KEEP;
			ctvs_pkg::ST_DIV: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31) state_d = ctvs_pkg::ST_DIV_FIX;
			end
			ctvs_pkg::ST_DIV_FIX: state_d = ctvs_pkg::ST_KEEP;
			ctvs_pkg::ST_KEEP: state_d = ctvs_pkg::ST_NEW;
			ctvs_pkg::ST_NEW: state_d = ctvs_pkg::ST_VEL;
			ctvs_pkg::ST_VEL: begin
				if (axis_q == 2'd2) begin
					state_d = ctvs_pkg::ST_SPD;
					axis_d  = '0;
				end else begin
					state_d = ctvs_pkg::ST_AXIS;
					axis_d  = axis_q + 2'd1;
				end
			end
			ctvs_pkg::ST_SPD: begin
				if (axis_q == 2'd2) state_d = ctvs_pkg::ST_FIN;
				else axis_d = axis_q + 2'd1;
			end
			ctvs_pkg::ST_FIN: state_d = ctvs_pkg::ST_OUT;
			ctvs_pkg::ST_OUT: begin
				if (out_free) state_d = ctvs_pkg::ST_IDLE;
			end
			default: state_d = ctvs_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd.op       = ctvs_pkg::OP_NONE;
		cmd.axis     = axis_q;
		cmd.out_load = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			ctvs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = ctvs_pkg::OP_LOAD;
			end
			ctvs_pkg::ST_DIFF:      cmd.op = ctvs_pkg::OP_DIFF;
			ctvs_pkg::ST_SQ:        cmd.op = ctvs_pkg::OP_SQ;
			ctvs_pkg::ST_ROOT_INIT: cmd.op = ctvs_pkg::OP_ROOT_INIT;
			ctvs_pkg::ST_ROOT:      cmd.op = ctvs_pkg::OP_ROOT_STEP;
			ctvs_pkg::ST_AXIS: begin
				cmd.op = stat.far ? ctvs_pkg::OP_DIV_MUL : ctvs_pkg::OP_DECAY_MUL;
			end
			ctvs_pkg::ST_DECAY:     cmd.op = ctvs_pkg::OP_DECAY_ROUND;
			ctvs_pkg::ST_DIV:       cmd.op = ctvs_pkg::OP_DIV_STEP;
			ctvs_pkg::ST_DIV_FIX:   cmd.op = ctvs_pkg::OP_DIV_FIX;
			ctvs_pkg::ST_KEEP:      cmd.op = ctvs_pkg::OP_KEEP;
			ctvs_pkg::ST_NEW:       cmd.op = ctvs_pkg::OP_NEW;
			ctvs_pkg::ST_VEL:       cmd.op = ctvs_pkg::OP_VEL;
			ctvs_pkg::ST_SPD:       cmd.op = ctvs_pkg::OP_SPD;
			ctvs_pkg::ST_FIN:       cmd.op = ctvs_pkg::OP_FIN;
			ctvs_pkg::ST_OUT:       cmd.out_load = out_free;
			default:                cmd.op = ctvs_pkg::OP_NONE;
		endcase
	end

endmodule

/* hdl/ctvs_dp.sv */
module ctvs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ctvs_pkg::dp_cmd_t  cmd,
	output ctvs_pkg::dp_stat_t stat,
	input  ctvs_pkg::cfg_t     cfg,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output ctvs_pkg::res_t     res
);

	logic signed [31:0] pos_q [3];
	logic signed [31:0] d_q [3];
	logic signed [31:0] prev_q [3];
	logic [63:0]        sq_q;
	logic [63:0]        rv_q;
	logic [31:0]        root_q;
	logic [33:0]        rrem_q;
	logic [31:0]        quo_q;
	logic [32:0]        drem_q;
	logic signed [64:0] acc_q;
	logic signed [31:0] raw_q;
	logic               done_q;

	logic signed [31:0] d_sel, prev_sel;
	logic [31:0]        d_mag;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic [62:0]        dividend;
	logic [35:0]        root_t;
	logic [33:0]        root_trial;
	logic [32:0]        div_t;
	logic [31:0]        q_pos;
	logic signed [31:0] q_signed;
	logic signed [31:0] target [3];

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v > 33'sh0_7FFF_FFFF) sat33 = 32'sh7FFF_FFFF;
		else if (v < -33'sh0_8000_0000) sat33 = 32'sh8000_0000;
		else sat33 = 32'(v);
	endfunction

	assign target[0] = cfg.goal_x;
	assign target[1] = cfg.goal_y;
	assign target[2] = cfg.goal_z;

	assign d_sel    = d_q[cmd.axis];
	assign prev_sel = prev_q[cmd.axis];
	assign d_mag    = d_sel[31] ? 32'(33'd0 - 33'(d_sel)) : 32'(d_sel);

	// One shared multiplier; each use is registered before the next.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			ctvs_pkg::OP_SQ: begin
				mul_a = 33'(d_mag);
				mul_b = 33'(d_mag);
			end
			ctvs_pkg::OP_DECAY_MUL: begin
				mul_a = 33'(prev_sel);
				mul_b = ctvs_pkg::CoefDecay;
			end
			ctvs_pkg::OP_DIV_MUL: begin
				mul_a = 33'(cfg.cruise_speed);
				mul_b = 33'(d_mag);
			end
			ctvs_pkg::OP_KEEP: begin
				mul_a = 33'(prev_sel);
				mul_b = ctvs_pkg::CoefKeep;
			end
			ctvs_pkg::OP_NEW: begin
				mul_a = 33'(raw_q);
				mul_b = ctvs_pkg::CoefNew;
			end
			ctvs_pkg::OP_SPD: begin
				mul_a = 33'(prev_sel);
				mul_b = 33'(prev_sel);
			end
			ctvs_pkg::OP_FIN: begin
				mul_a = 33'(cfg.finish_speed);
				mul_b = 33'(cfg.finish_speed);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign dividend = prod[62:0] + 63'(root_q >> 1);

	// Square root: two radicand bits per step, one root bit out.
	assign root_t     = {rrem_q, rv_q[63:62]};
	assign root_trial = {root_q, 2'b01};

	// Long division: one quotient bit per step.
	assign div_t = {drem_q[31:0], quo_q[31]};

	assign q_pos    = quo_q;
	assign q_signed = (q_pos > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q[0] <= '0;
			prev_q[1] <= '0;
			prev_q[2] <= '0;
		end else if (cmd.op == ctvs_pkg::OP_VEL) begin
			prev_q[cmd.axis] <= ctvs_pkg::round_sat(acc_q);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op) inside
			ctvs_pkg::OP_LOAD: begin
				pos_q[0] <= pos_x;
				pos_q[1] <= pos_y;
				pos_q[2] <= pos_z;
			end
			ctvs_pkg::OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					d_q[i] <= sat33(33'(target[i]) - 33'(pos_q[i]));
				end
			end
			ctvs_pkg::OP_SQ, ctvs_pkg::OP_SPD: begin
				sq_q <= ((cmd.axis == 2'd0) ? 64'd0 : sq_q) + prod[63:0];
			end
			ctvs_pkg::OP_ROOT_INIT: begin
				rv_q   <= sq_q;
				root_q <= '0;
				rrem_q <= '0;
			end
			ctvs_pkg::OP_ROOT_STEP: begin
				rv_q <= {rv_q[61:0], 2'b00};
				if (root_t >= 36'(root_trial)) begin
					rrem_q <= 34'(root_t - 36'(root_trial));
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rrem_q <= root_t[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			ctvs_pkg::OP_DECAY_MUL, ctvs_pkg::OP_KEEP: acc_q <= prod[64:0];
			ctvs_pkg::OP_NEW: acc_q <= acc_q + prod[64:0];
			ctvs_pkg::OP_DECAY_ROUND: raw_q <= ctvs_pkg::round_sat(acc_q);
			ctvs_pkg::OP_DIV_MUL: begin
				drem_q <= 33'(dividend[62:32]);
				quo_q  <= dividend[31:0];
			end
			ctvs_pkg::OP_DIV_STEP: begin
				if (div_t >= 33'(root_q)) begin
					drem_q <= div_t - 33'(root_q);
					quo_q  <= {quo_q[30:0], 1'b1};
				end else begin
					drem_q <= div_t;
					quo_q  <= {quo_q[30:0], 1'b0};
				end
			end
			ctvs_pkg::OP_DIV_FIX: begin
				// A zero distance leaves no direction, so the raw velocity is zero.
				if (root_q == 32'd0) raw_q <= '0;
				else if (!d_sel[31]) raw_q <= q_signed;
				else if (q_pos > 32'h8000_0000) raw_q <= 32'sh8000_0000;
				else raw_q <= 32'(33'd0 - 33'(q_pos));
			end
			ctvs_pkg::OP_FIN: done_q <= sq_q < prod[63:0];
			default: ;
		endcase
	end

	assign stat.far = 33'(root_q) >= 33'(cfg.stop_radius);

	assign res.finished = done_q;
	assign res.vel_x    = done_q ? 32'sd0 : prev_q[0];
	assign res.vel_y    = done_q ? 32'sd0 : prev_q[1];
	assign res.vel_z    = done_q ? 32'sd0 : prev_q[2];

endmodule

/* hdl/cartesian_target_velocity_steer_core.sv */
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  measured position pos_x, pos_y, pos_z
// m_*       out  m_tvalid/m_tready  commanded velocity and finished flag
// cfg_*     in   cfg_we             target, cruise speed, stop radius, finish speed
//
// The 32-step square root runs once per item; the 32-step divider runs once
// per axis only when the block steers, not when the position lies inside the
// stop radius.
// arst_n clears the control state and the stored velocity and returns the
// configuration to its reset values.
// A completed result waits in the output register while the next item is taken
// in; a stalled output holds the controller before it overwrites that register.
module cartesian_target_velocity_steer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // pos_x, pos_y, pos_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // cmd_vel_x, cmd_vel_y, cmd_vel_z
	output logic [0:0]  m_tuser,   // finished
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ctvs_pkg::cfg_t     cfg_q;
	ctvs_pkg::dp_cmd_t  cmd;
	ctvs_pkg::dp_stat_t stat;
	ctvs_pkg::res_t     res;
	logic               out_valid_q;
	logic [95:0]        out_data_q;
	logic               out_user_q;
	logic               out_free;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.goal_x       <= '0;
			cfg_q.goal_y       <= '0;
			cfg_q.goal_z       <= '0;
			cfg_q.cruise_speed <= ctvs_pkg::ResetCruise;
			cfg_q.stop_radius  <= ctvs_pkg::ResetStop;
			cfg_q.finish_speed <= ctvs_pkg::ResetFinish;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctvs_pkg::CFG_GOAL_X: cfg_q.goal_x       <= cfg_data;
				ctvs_pkg::CFG_GOAL_Y: cfg_q.goal_y       <= cfg_data;
				ctvs_pkg::CFG_GOAL_Z: cfg_q.goal_z       <= cfg_data;
				ctvs_pkg::CFG_CRUISE: cfg_q.cruise_speed <= cfg_data[30:0];
				ctvs_pkg::CFG_STOP:   cfg_q.stop_radius  <= cfg_data[30:0];
				ctvs_pkg::CFG_FINISH: cfg_q.finish_speed <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// The output register frees up in the cycle its item is taken.
	assign out_free = !out_valid_q || m_tready;

	ctvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	ctvs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.cfg    (cfg_q),
		.pos_x  (s_tdata[31:0]),
		.pos_y  (s_tdata[63:32]),
		.pos_z  (s_tdata[95:64]),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {res.vel_z, res.vel_y, res.vel_x};
			out_user_q <= res.finished;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

/* hdl/ctvs_checker.sv */
`include "cartesian_target_velocity_steer_core_defines.svh"

module ctvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result holds still.
	`CTVS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A finished result always carries zero velocity.
	`CTVS_ASSERT(a_finished_zero, !(m_tvalid && m_tuser[0]) || m_tdata == 96'd0)

	// The block works on one item at a time.
	`CTVS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// No result can appear right after an item is taken in.
	`CTVS_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

endmodule

bind cartesian_target_velocity_steer_core ctvs_checker u_ctvs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
